@@ rtl/core/amdfs_pkg.sv @@
// Shared constants and types for the adjacency-matrix depth-first search core.
// No dependencies; compile before the modules.
`timescale 1ns / 1ps
`default_nettype none

package amdfs_pkg;

    // Fixed field widths of the ports
    localparam int NODE_W = 5;           // node number on the ports
    localparam int CFG_W  = 6;           // node_count register
    localparam int N_W    = CFG_W + 1;   // width for node-count compares

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(32);

    // At most this many results per search
    localparam int RESULT_CAP = 32;
    localparam int CAP_W      = 6;

    // Operation codes
    localparam logic OP_CONNECT = 1'b0;
    localparam logic OP_SEARCH  = 1'b1;

    // Control strobes toward the adjacency row memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } adj_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/adjacency_matrix_dfs_order_core.sv @@
// Depth-first search over an undirected adjacency matrix held in block memory.
// Connect reads row a, writes row a while reading row b, then writes row b. Search
// pushes nodes and pops them through adjacency and stack memory reads.
// One item at a time; input ready only while idle. Output stalls pause the walk until the result cap is reached.
// Reset (synchronous, aresetn low): no edges, node_count = 32, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_dfs_order_core #(
    parameter int MAX_NODES = 32
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // node_count register write
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [amdfs_pkg::CFG_W-1:0]   cfg_data,
    // items
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_operation,
    input  wire  [amdfs_pkg::NODE_W-1:0]  s_node_a,
    input  wire  [amdfs_pkg::NODE_W-1:0]  s_node_b,
    // visiting order
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [amdfs_pkg::NODE_W-1:0]  m_visited_node,
    output logic                          m_last
);
    import amdfs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CONN_A = 3'd1;   // write row a, read row b
    localparam logic [2:0] S_CONN_B = 3'd2;   // write row b
    localparam logic [2:0] S_CHECK  = 3'd3;   // loop test, read row of top
    localparam logic [2:0] S_SCAN   = 3'd4;   // pick neighbor or pop
    localparam logic [2:0] S_POP    = 3'd5;   // new top from stack memory
    localparam logic [2:0] S_FINISH = 3'd6;   // emit final node

    localparam logic [MAX_NODES-1:0] ONE_BIT = MAX_NODES'(1);

    // ---------------- registers ----------------
    logic [2:0]           state_reg, state_next;
    logic [CFG_W-1:0]     node_count_reg;
    logic [NODE_W-1:0]    arg_a_reg, arg_a_next;
    logic [NODE_W-1:0]    arg_b_reg, arg_b_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [CNT_W-1:0]     vcount_reg, vcount_next;
    logic [CNT_W-1:0]     depth_reg, depth_next;
    logic [NODE_W-1:0]    top_reg, top_next;
    logic [NODE_W-1:0]    pend_reg, pend_next;   // found node not yet emitted
    logic [CAP_W-1:0]     emit_cnt_reg, emit_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [NODE_W-1:0]    m_node_reg, m_node_next;
    logic                 m_last_reg, m_last_next;

    // ---------------- memories ----------------
    adj_ctl_t             adj_ctl;
    logic [ADDR_W-1:0]    adj_rd_addr, adj_wr_addr;
    logic [MAX_NODES-1:0] adj_wr_data, adj_rd_data;

    logic [NODE_W-1:0]    stack_mem [MAX_NODES];
    logic [NODE_W-1:0]    stk_rd_reg;
    logic                 stk_we, stk_re;
    logic [ADDR_W-1:0]    stk_wr_addr, stk_rd_addr;
    logic [NODE_W-1:0]    stk_wr_data;

    amdfs_adj_ram #(
        .DEPTH  (MAX_NODES),
        .ADDR_W (ADDR_W)
    ) u_adj_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (adj_ctl),
        .rd_addr (adj_rd_addr),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_data (adj_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_re) begin
            stk_rd_reg <= stack_mem[stk_rd_addr];
        end
    end

    // ---------------- derived values ----------------
    logic [N_W-1:0]       n_active;
    logic [MAX_NODES-1:0] all_mask;
    logic [MAX_NODES-1:0] cand;
    logic [ADDR_W-1:0]    next_idx;
    logic                 out_free;
    logic                 s_xfer;
    logic                 a_in_range, b_in_range;
    logic                 walk_done;

    assign n_active = (N_W'(node_count_reg) > N_W'(MAX_NODES)) ? N_W'(MAX_NODES)
                                                              : N_W'(node_count_reg);

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            all_mask[i] = (N_W'(i) < n_active);
        end
    end

    assign cand = adj_rd_data & all_mask & ~visited_reg;

    // lowest set candidate bit
    always_comb begin
        next_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                next_idx = ADDR_W'(i);
            end
        end
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == S_IDLE);
    assign s_xfer     = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign a_in_range = (N_W'(s_node_a) < n_active);
    assign b_in_range = (N_W'(s_node_b) < n_active);
    assign walk_done  = (depth_reg == '0) || (N_W'(vcount_reg) == n_active);

    // ---------------- control ----------------
    always_comb begin
        state_next    = state_reg;
        arg_a_next    = arg_a_reg;
        arg_b_next    = arg_b_reg;
        visited_next  = visited_reg;
        vcount_next   = vcount_reg;
        depth_next    = depth_reg;
        top_next      = top_reg;
        pend_next     = pend_reg;
        emit_cnt_next = emit_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_node_next   = m_node_reg;
        m_last_next   = m_last_reg;

        adj_ctl       = '0;
        adj_rd_addr   = ADDR_W'(s_node_a);
        adj_wr_addr   = ADDR_W'(arg_a_reg);
        adj_wr_data   = adj_rd_data | (ONE_BIT << ADDR_W'(arg_b_reg));

        stk_we        = 1'b0;
        stk_re        = 1'b0;
        stk_wr_addr   = ADDR_W'(depth_reg);
        stk_wr_data   = NODE_W'(next_idx);
        stk_rd_addr   = ADDR_W'(depth_reg - CNT_W'(2));

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    arg_a_next = s_node_a;
                    arg_b_next = s_node_b;
                    if (s_operation == OP_CONNECT) begin
                        if (a_in_range && b_in_range) begin
                            adj_ctl.rd_en = 1'b1;
                            state_next    = S_CONN_A;
                        end
                    end else if (a_in_range) begin
                        // start node: visited, pushed, held for emission
                        visited_next  = ONE_BIT << ADDR_W'(s_node_a);
                        vcount_next   = CNT_W'(1);
                        depth_next    = CNT_W'(1);
                        stk_we        = 1'b1;
                        stk_wr_addr   = '0;
                        stk_wr_data   = s_node_a;
                        top_next      = s_node_a;
                        pend_next     = s_node_a;
                        emit_cnt_next = CAP_W'(1);
                        state_next    = S_CHECK;
                    end
                end
            end
            S_CONN_A: begin
                adj_ctl.wr_en = 1'b1;
                adj_ctl.rd_en = 1'b1;
                adj_rd_addr   = ADDR_W'(arg_b_reg);
                state_next    = S_CONN_B;
            end
            S_CONN_B: begin
                adj_ctl.wr_en = 1'b1;
                adj_wr_addr   = ADDR_W'(arg_b_reg);
                adj_wr_data   = adj_rd_data | (ONE_BIT << ADDR_W'(arg_a_reg));
                state_next    = S_IDLE;
            end
            S_CHECK: begin
                if (walk_done) begin
                    state_next = S_FINISH;
                end else begin
                    adj_ctl.rd_en = 1'b1;
                    adj_rd_addr   = ADDR_W'(top_reg);
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cand == '0) begin
                    depth_next = depth_reg - CNT_W'(1);
                    if (depth_reg > CNT_W'(1)) begin
                        stk_re     = 1'b1;
                        state_next = S_POP;
                    end else begin
                        state_next = S_CHECK;
                    end
                end else if (emit_cnt_reg < CAP_W'(RESULT_CAP)) begin
                    // found node displaces the held one, which is not last
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_node_next   = pend_reg;
                        m_last_next   = 1'b0;
                        pend_next     = NODE_W'(next_idx);
                        emit_cnt_next = emit_cnt_reg + CAP_W'(1);
                        visited_next  = visited_reg | (ONE_BIT << next_idx);
                        vcount_next   = vcount_reg + CNT_W'(1);
                        stk_we        = (depth_reg < CNT_W'(MAX_NODES));
                        depth_next    = stk_we ? depth_reg + CNT_W'(1) : depth_reg;
                        top_next      = NODE_W'(next_idx);
                        state_next    = S_CHECK;
                    end
                end else begin
                    // result cap reached: keep walking, emit nothing
                    visited_next = visited_reg | (ONE_BIT << next_idx);
                    vcount_next  = vcount_reg + CNT_W'(1);
                    stk_we       = (depth_reg < CNT_W'(MAX_NODES));
                    depth_next   = stk_we ? depth_reg + CNT_W'(1) : depth_reg;
                    top_next     = NODE_W'(next_idx);
                    state_next   = S_CHECK;
                end
            end
            S_POP: begin
                top_next   = stk_rd_reg;
                state_next = S_CHECK;
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_node_next  = pend_reg;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_RESET;
            visited_reg    <= '0;
            vcount_reg     <= '0;
            depth_reg      <= '0;
            emit_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            visited_reg  <= visited_next;
            vcount_reg   <= vcount_next;
            depth_reg    <= depth_next;
            emit_cnt_reg <= emit_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        arg_a_reg  <= arg_a_next;
        arg_b_reg  <= arg_b_next;
        top_reg    <= top_next;
        pend_reg   <= pend_next;
        m_node_reg <= m_node_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_visited_node = m_node_reg;
    assign m_last         = m_last_reg;

    // ---------------- checks ----------------
    a_visit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(visited_reg) == 32'(vcount_reg))
        else $error("visited count out of step with visited bits");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CNT_W'(MAX_NODES))
        else $error("stack depth beyond node count");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (depth_reg != '0))
        else $error("row scan with empty stack");

    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && out_free) |=> (m_valid_reg && m_last_reg
                                                && state_reg == S_IDLE))
        else $error("final node not marked last");

    a_emit_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_cnt_reg <= CAP_W'(RESULT_CAP))
        else $error("more results than the cap");

endmodule

`default_nettype wire

@@ rtl/core/amdfs_adj_ram.sv @@
// Adjacency row memory: one row per node, one read and one write port,
// registered read, per-row valid bits so unwritten rows read as zero.
// Depends on amdfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amdfs_adj_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  amdfs_pkg::adj_ctl_t      ctl,
    input  wire  [ADDR_W-1:0]        rd_addr,
    input  wire  [ADDR_W-1:0]        wr_addr,
    input  wire  [DEPTH-1:0]         wr_data,
    output logic [DEPTH-1:0]         rd_data
);
    import amdfs_pkg::*;

    logic [DEPTH-1:0] row_mem [DEPTH];
    logic [DEPTH-1:0] row_valid_reg;
    logic [DEPTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            row_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (ctl.wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // rows never written since reset have no edges
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire
